// ----- src/scbp_pkg.sv -----
// Shared types, constants and class table for the size class buffer pool.
package scbp_pkg;

	localparam int NUM_CLASSES   = 7;
	localparam int TOTAL_BUFFERS = 82;
	localparam int MAX_COUNT     = 20;

	localparam int SIZE_W   = 12;
	localparam int HANDLE_W = 7;
	localparam int CLASS_W  = $clog2(NUM_CLASSES);
	localparam int POS_W    = $clog2(MAX_COUNT);

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 16;

	localparam int unsigned CLASS_BYTES [NUM_CLASSES] = '{16, 32, 64, 128, 256, 512, 1024};
	localparam int unsigned CLASS_COUNT [NUM_CLASSES] = '{20, 20, 10, 10, 10, 10, 2};

	// first global handle of a class: running sum of the counts below it
	function automatic int unsigned class_base(input int c);
		int unsigned acc;
		acc = 0;
		for (int i = 0; i < c; i++) begin
			acc = acc + CLASS_COUNT[i];
		end
		return acc;
	endfunction

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOBUF   = 2'd1,
		ST_ALREADY = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	typedef struct packed {
		logic               hit;
		logic [CLASS_W-1:0] cls;
	} class_sel_t;

	typedef struct packed {
		kind_t               kind;
		class_sel_t          sel;
		logic [HANDLE_W-1:0] handle;
	} pool_req_t;

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] handle;
	} pool_res_t;

endpackage

// ----- src/scbp_class_sel.sv -----
// Maps a requested size to the smallest size class that holds it.
module scbp_class_sel
	import scbp_pkg::*;
(
	input  logic [SIZE_W-1:0] request_size,
	output class_sel_t        sel
);

	always_comb begin
		sel.hit = 1'b0;
		sel.cls = '0;
		// walk down so the smallest fitting class wins
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if ({20'd0, request_size} <= CLASS_BYTES[c]) begin
				sel.hit = 1'b1;
				sel.cls = CLASS_W'(c);
			end
		end
	end

endmodule

// ----- src/scbp_free_map.sv -----
// Free bitmap with per-class highest-free search, grant and release.
module scbp_free_map
	import scbp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pool_req_t req,
	input  logic      commit,
	output pool_res_t res
);

	logic [TOTAL_BUFFERS-1:0] free_map_q;
	logic [TOTAL_BUFFERS-1:0] free_map_d;
	logic [MAX_COUNT-1:0]     win;
	logic [POS_W-1:0]         pos;
	logic                     found;
	logic                     handle_ok;
	logic                     handle_free;

	// free bits of the selected class, lowest handle at bit 0
	always_comb begin
		int idx;
		win = '0;
		for (int j = 0; j < MAX_COUNT; j++) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				idx = int'(class_base(c)) + j;
				if (req.sel.cls == CLASS_W'(c) && j < int'(CLASS_COUNT[c])
						&& idx < TOTAL_BUFFERS) begin
					win[j] = free_map_q[idx[HANDLE_W-1:0]];
				end
			end
		end
	end

	// highest free slot wins
	always_comb begin
		pos   = '0;
		found = 1'b0;
		for (int j = 0; j < MAX_COUNT; j++) begin
			if (win[j]) begin
				pos   = POS_W'(j);
				found = 1'b1;
			end
		end
	end

	assign handle_ok   = ({25'd0, req.handle} < TOTAL_BUFFERS);
	assign handle_free = handle_ok && free_map_q[req.handle];

	always_comb begin
		logic [HANDLE_W-1:0] base;
		logic [HANDLE_W-1:0] grant;
		base = '0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			if (req.sel.cls == CLASS_W'(c)) begin
				base = HANDLE_W'(class_base(c));
			end
		end
		grant      = base + HANDLE_W'(pos);
		free_map_d = free_map_q;
		res.status = ST_NOBUF;
		res.handle = '0;
		unique case (req.kind)
			KIND_ALLOC: begin
				if (req.sel.hit && found) begin
					res.status        = ST_OK;
					res.handle        = grant;
					free_map_d[grant] = 1'b0;
				end
			end
			KIND_FREE: begin
				if (!handle_ok) begin
					res.status = ST_INVALID;
				end else if (handle_free) begin
					res.status = ST_ALREADY;
				end else begin
					res.status             = ST_OK;
					res.handle             = req.handle;
					free_map_d[req.handle] = 1'b1;
				end
			end
			default: begin
				res.status = ST_NOBUF;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_map_q <= '1;
		end else if (commit) begin
			free_map_q <= free_map_d;
		end
	end

endmodule

// ----- src/size_class_buffer_pool_unit.sv -----
// Top level of the size class buffer pool: input register, pool logic, result register.
// Fixed pool of 82 buffers in seven size classes (16 to 1024 bytes; 20,20,10,10,10,10,2
// buffers, handles numbered in class order). An allocate item gets the highest free handle
// of the smallest class that fits, or status 1; a free item returns a handle, or reports
// an already free (2) or invalid (3) handle. Every item gives exactly one result item.
// Items pass the input register, then the result register; one item is taken each cycle
// unless m_tready stalls the output, as class search and bitmap update sit between those registers.
// The pool comes out of reset with every buffer free, no initialisation sweep.
module size_class_buffer_pool_unit
	import scbp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // request_size[11:0], buffer_handle[18:12]
	input  logic                  s_tuser,  // kind[0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // status[1:0], granted_handle[8:2]
);

	logic                  valid_s1;
	kind_t                 kind_s1;
	logic [SIZE_W-1:0]     size_s1;
	logic [HANDLE_W-1:0]   handle_s1;
	logic                  m_tvalid_q;
	pool_res_t             res_q;
	logic                  advance;
	logic                  commit;
	class_sel_t            sel;
	pool_req_t             req;
	pool_res_t             res;

	assign advance  = !m_tvalid_q || m_tready;
	assign commit   = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			kind_s1   <= kind_t'(s_tuser);
			size_s1   <= s_tdata[SIZE_W-1:0];
			handle_s1 <= s_tdata[SIZE_W +: HANDLE_W];
		end
	end

	scbp_class_sel u_class_sel (
		.request_size (size_s1),
		.sel          (sel)
	);

	assign req.kind   = kind_s1;
	assign req.sel    = sel;
	assign req.handle = handle_s1;

	scbp_free_map u_free_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.commit (commit),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - 2 - HANDLE_W){1'b0}}, res_q.handle, res_q.status};

endmodule

// ----- tb/sv/tb_size_class_buffer_pool_unit.sv -----
// Self-checking testbench for the size class buffer pool: stream stimulus, own pool predictor.
module tb_size_class_buffer_pool_unit;
	import scbp_pkg::*;

	localparam int POOL_SIZE   = 82;
	localparam int SLOTS       = 7;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 300000;

	localparam int unsigned SLOT_BYTES [SLOTS] = '{16, 32, 64, 128, 256, 512, 1024};
	localparam int unsigned SLOT_COUNT [SLOTS] = '{20, 20, 10, 10, 10, 10, 2};

	typedef struct {
		status_t    status;
		logic [6:0] handle;
	} grant_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;
	logic                  s_tuser  = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;

	// predictor state: 1 = buffer free
	logic [POOL_SIZE-1:0] pool_free = '1;
	grant_t               grants_due [$];

	int  errors      = 0;
	int  cycles      = 0;
	int  grants_seen = 0;
	int  n_items     = 0;
	int  n_alloc_ok  = 0;
	int  n_alloc_nak = 0;
	int  n_free_ok   = 0;
	int  n_double    = 0;
	int  n_invalid   = 0;
	bit  calm        = 1'b0;
	int  hold_reqs   = 0;
	int  hold_seen   = 0;
	int  hold_left   = 0;

	size_class_buffer_pool_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	// smallest fitting class, highest free buffer in it, no fallback upwards
	function automatic grant_t pool_predict(kind_t k, logic [11:0] sz, logic [6:0] h);
		grant_t g;
		int     base;
		bit     fitted;
		g.status = ST_NOBUF;
		g.handle = '0;
		base     = 0;
		fitted   = 1'b0;
		if (k == KIND_ALLOC) begin
			for (int c = 0; c < SLOTS; c++) begin
				if (!fitted && sz <= SLOT_BYTES[c]) begin
					fitted = 1'b1;
					for (int i = SLOT_COUNT[c] - 1; i >= 0; i--) begin
						if (g.status != ST_OK && base + i < POOL_SIZE && pool_free[base + i]) begin
							pool_free[base + i] = 1'b0;
							g.status = ST_OK;
							g.handle = 7'(base + i);
						end
					end
				end
				base += SLOT_COUNT[c];
			end
			if (g.status == ST_OK) n_alloc_ok++;
			else n_alloc_nak++;
		end else if (h >= POOL_SIZE) begin
			g.status = ST_INVALID;
			n_invalid++;
		end else if (pool_free[h]) begin
			g.status = ST_ALREADY;
			n_double++;
		end else begin
			pool_free[h] = 1'b1;
			g.status = ST_OK;
			g.handle = h;
			n_free_ok++;
		end
		return g;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		errors++;
		$display("mismatch at result %0d: %s got %0d, wanted %0d", grants_seen, what, got, want);
	endtask

	// one item; valid stays high from one item to the next unless an idle cycle falls between
	task automatic send_item(kind_t k, int unsigned sz, int unsigned h);
		while (!calm && $urandom_range(99) < 33) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= k;
		s_tdata  <= {{(IN_DATA_W - 19){1'b0}}, 7'(h), 12'(sz)};
		do @(posedge clk); while (!s_tready);
		grants_due.push_back(pool_predict(k, 12'(sz), 7'(h)));
		n_items++;
	endtask

	task automatic send_alloc(int unsigned sz);
		send_item(KIND_ALLOC, sz, $urandom_range(127));
	endtask

	task automatic send_free(int unsigned h);
		send_item(KIND_FREE, $urandom_range(4095), h);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (grants_due.size() != 0) @(posedge clk);
	endtask

	function automatic int unsigned used_handle();
		int unsigned start;
		start = $urandom_range(POOL_SIZE - 1);
		for (int i = 0; i < POOL_SIZE; i++) begin
			if (!pool_free[(start + i) % POOL_SIZE]) return (start + i) % POOL_SIZE;
		end
		return start;
	endfunction

	function automatic int unsigned size_in_class(int c);
		int unsigned lo;
		lo = (c == 0) ? 0 : SLOT_BYTES[c - 1] + 1;
		return $urandom_range(SLOT_BYTES[c], lo);
	endfunction

	task automatic random_item();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 42) send_alloc(size_in_class($urandom_range(SLOTS - 1)));
		else if (pick < 47) send_alloc($urandom_range(4095, 1025));
		else if (pick < 50) send_alloc($urandom_range(1) ? 0 : 4095);
		else if (pick < 85) send_free(used_handle());
		else if (pick < 92) send_free($urandom_range(POOL_SIZE - 1));
		else send_free($urandom_range(127, POOL_SIZE));
	endtask

	// class edges, oversize, double free, invalid handles, largest class running dry
	task automatic test_directed();
		send_alloc(0);
		send_alloc(16);
		send_alloc(17);
		send_alloc(32);
		send_alloc(33);
		send_alloc(64);
		send_alloc(65);
		send_alloc(128);
		send_alloc(129);
		send_alloc(256);
		send_alloc(257);
		send_alloc(512);
		send_alloc(513);
		send_alloc(1024);
		send_alloc(1025);
		send_item(KIND_ALLOC, 4095, 127);
		send_free(81);
		send_free(81);
		send_free(POOL_SIZE);
		send_item(KIND_FREE, 0, 127);
		send_item(KIND_FREE, 4095, 0);
		send_free(19);
		send_alloc(1000);
		send_alloc(1024);
		wait_drained();
	endtask

	// fill every class past its end, then hand every buffer back
	task automatic test_exhaust();
		for (int c = 0; c < SLOTS; c++) begin
			for (int i = 0; i <= SLOT_COUNT[c]; i++) begin
				send_alloc($urandom_range(1) ? SLOT_BYTES[c] : size_in_class(c));
			end
		end
		for (int h = POOL_SIZE - 1; h >= 0; h--) send_free(h);
		wait_drained();
	endtask

	// receiver holds off while items keep coming, so the block fills and stalls its input
	task automatic test_backpressure();
		hold_reqs <= hold_reqs + 1;
		for (int i = 0; i < 60; i++) random_item();
		wait_drained();
	endtask

	task automatic test_no_idle();
		calm <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < 200; i++) random_item();
		calm <= 1'b0;
		wait_drained();
	endtask

	task automatic test_random();
		for (int i = 0; i < 1400; i++) begin
			random_item();
			if (i % 350 == 349) wait_drained();
		end
		wait_drained();
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 33);
		end
	end

	always @(posedge clk) begin
		grant_t want;
		if (arst_n && m_tvalid && m_tready) begin
			grants_seen++;
			if (grants_due.size() == 0) begin
				report_mismatch("results outstanding", 1, 0);
			end else begin
				want = grants_due.pop_front();
				if (m_tdata[1:0] != want.status)
					report_mismatch("status", m_tdata[1:0], want.status);
				if (m_tdata[8:2] != want.handle)
					report_mismatch("granted_handle", m_tdata[8:2], want.handle);
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles, grants_due.size());
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_exhaust();
		test_backpressure();
		test_no_idle();
		test_random();
		wait_drained();
		repeat (8) @(posedge clk);
		$display("%0d items, %0d results: alloc %0d granted / %0d refused, free %0d ok",
			n_items, grants_seen, n_alloc_ok, n_alloc_nak, n_free_ok);
		$display("%0d double frees, %0d invalid handles, %0d mismatches",
			n_double, n_invalid, errors);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
